### hdl/gtc_pkg.sv
// Shared types, codes and constants for the touch gesture classifier.
package gtc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int OP_W           = 3;
  localparam int GESTURE_W      = 3;
  localparam int STATUS_W       = 4;
  localparam int TICK_W         = 14;
  localparam int SWIPE_W        = 12;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 4;

  localparam logic [TICK_W-1:0]   TICK_LIMIT   = 14'd10000;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT = 4'd10;
  localparam logic [STATUS_W-1:0] STATUS_ARM   = 4'd1;

  localparam logic [SWIPE_W-1:0] SWIPE_RST = 12'd10;
  localparam logic [TICK_W-1:0]  TAP_RST   = 14'd30;
  localparam logic [TICK_W-1:0]  HOLD_RST  = 14'd150;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SWIPE = 2'd0;
  localparam logic [1:0] REG_TAP   = 2'd1;
  localparam logic [1:0] REG_HOLD  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ARM  = 3'd0,
    OP_TICK = 3'd1,
    OP_DOWN = 3'd2,
    OP_UP   = 3'd3,
    OP_EVAL = 3'd4
  } op_t;

  typedef enum logic [GESTURE_W-1:0] {
    G_TAP   = 3'd0,
    G_LEFT  = 3'd1,
    G_RIGHT = 3'd2,
    G_UP    = 3'd3,
    G_DOWN  = 3'd4,
    G_LONG  = 3'd5
  } gesture_t;

  typedef struct packed {
    logic [SWIPE_W-1:0] swipe_min_distance;
    logic [TICK_W-1:0]  tap_max_ticks;
    logic [TICK_W-1:0]  hold_min_ticks;
  } cfg_t;

endpackage

### hdl/gtc_event_if.sv
// Event channel: valid/ready with one touch event word.
interface gtc_event_if #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [gtc_pkg::OP_W-1:0] operation;
  logic [COORD_BITS-1:0]    x_coord;
  logic [COORD_BITS-1:0]    y_coord;

  modport source (output valid, operation, x_coord, y_coord, input ready);
  modport sink (input valid, operation, x_coord, y_coord, output ready);
endinterface

### hdl/gtc_result_if.sv
// Result channel: valid/ready with one classification word.
interface gtc_result_if #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          gesture_valid;
  logic [gtc_pkg::GESTURE_W-1:0] gesture;
  logic [COORD_BITS-1:0]         origin_x;
  logic [COORD_BITS-1:0]         origin_y;
  logic [gtc_pkg::STATUS_W-1:0]  press_status;

  modport source (output valid, gesture_valid, gesture, origin_x, origin_y, press_status,
                  input ready);
  modport sink (input valid, gesture_valid, gesture, origin_x, origin_y, press_status,
                output ready);
endinterface

### hdl/gtc_regs.sv
// APB threshold registers.
module gtc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gtc_pkg::ADDR_W-1:0] paddr,
  input  logic [gtc_pkg::DATA_W-1:0] pwdata,
  output logic [gtc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gtc_pkg::cfg_t              cfg
);
  import gtc_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swipe_min_distance <= SWIPE_RST;
      cfg.tap_max_ticks      <= TAP_RST;
      cfg.hold_min_ticks     <= HOLD_RST;
    end else if (wr) begin
      case (idx)
        REG_SWIPE: cfg.swipe_min_distance <= pwdata[SWIPE_W-1:0];
        REG_TAP:   cfg.tap_max_ticks      <= pwdata[TICK_W-1:0];
        REG_HOLD:  cfg.hold_min_ticks     <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SWIPE: prdata = DATA_W'(cfg.swipe_min_distance);
      REG_TAP:   prdata = DATA_W'(cfg.tap_max_ticks);
      REG_HOLD:  prdata = DATA_W'(cfg.hold_min_ticks);
      default:   prdata = '0;
    endcase
  end

endmodule

### hdl/gtc_engine.sv
// Contact state registers, their update and the gesture decision.
module gtc_engine #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gtc_pkg::cfg_t                 cfg,
  input  logic                          step,
  input  gtc_pkg::op_t                  op,
  input  logic [COORD_BITS-1:0]         x,
  input  logic [COORD_BITS-1:0]         y,
  output logic                          gesture_valid,
  output logic [gtc_pkg::GESTURE_W-1:0] gesture,
  output logic [COORD_BITS-1:0]         origin_x,
  output logic [COORD_BITS-1:0]         origin_y,
  output logic [gtc_pkg::STATUS_W-1:0]  press_status
);
  import gtc_pkg::*;

  localparam int CMP_W = (COORD_BITS > SWIPE_W) ? COORD_BITS : SWIPE_W;

  logic [STATUS_W-1:0]   status, status_next;
  logic [TICK_W-1:0]     ticks, ticks_next;
  logic [COORD_BITS-1:0] down_x, down_x_next, down_y, down_y_next;
  logic [COORD_BITS-1:0] up_x, up_x_next, up_y, up_y_next;

  logic [COORD_BITS-1:0] dx, dy;
  logic [CMP_W-1:0]      dx_w, dy_w, swipe_w;
  logic                  found;
  gesture_t              g;

  always_comb begin
    status_next = status;
    ticks_next  = ticks;
    down_x_next = down_x;
    down_y_next = down_y;
    up_x_next   = up_x;
    up_y_next   = up_y;
    case (op)
      OP_ARM: begin
        status_next = STATUS_ARM;
        ticks_next  = '0;
        down_x_next = '0;
        down_y_next = '0;
        up_x_next   = '0;
        up_y_next   = '0;
      end
      OP_TICK: begin
        ticks_next = (ticks >= TICK_LIMIT) ? TICK_LIMIT : ticks + 1'b1;
      end
      OP_DOWN: begin
        status_next = (status >= STATUS_LIMIT - 1'b1) ? STATUS_LIMIT : status + 1'b1;
        down_x_next = x;
        down_y_next = y;
      end
      OP_UP: begin
        up_x_next = x;
        up_y_next = y;
      end
      OP_EVAL: status_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      ticks  <= '0;
      down_x <= '0;
      down_y <= '0;
      up_x   <= '0;
      up_y   <= '0;
    end else if (step) begin
      status <= status_next;
      ticks  <= ticks_next;
      down_x <= down_x_next;
      down_y <= down_y_next;
      up_x   <= up_x_next;
      up_y   <= up_y_next;
    end
  end

  // evaluate leaves the points and ticks untouched, so decide on the current state
  assign dx      = (down_x > up_x) ? down_x - up_x : up_x - down_x;
  assign dy      = (down_y > up_y) ? down_y - up_y : up_y - down_y;
  assign dx_w    = CMP_W'(dx);
  assign dy_w    = CMP_W'(dy);
  assign swipe_w = CMP_W'(cfg.swipe_min_distance);

  always_comb begin
    found = 1'b0;
    g     = G_TAP;
    priority if (up_x == '0 && up_y == '0 && down_x != '0 && down_y != '0) begin
      found = 1'b1;
    end else if (dx_w > dy_w && dx_w > swipe_w) begin
      found = 1'b1;
      g     = (down_x > up_x) ? G_LEFT : G_RIGHT;
    end else if (dx_w <= dy_w && dy_w > swipe_w) begin
      found = 1'b1;
      g     = (down_y > up_y) ? G_UP : G_DOWN;
    end else if (ticks < cfg.tap_max_ticks) begin
      found = ((down_x | down_y | up_x | up_y) != '0);
    end else if (ticks > cfg.hold_min_ticks) begin
      found = !(down_x != '0 && down_y != '0 && up_x != '0 && up_y != '0);
      g     = G_LONG;
    end else begin
      found = 1'b0;
    end
  end

  assign gesture_valid = (op == OP_EVAL) && found;
  assign gesture       = gesture_valid ? g : G_TAP;
  assign origin_x      = gesture_valid ? down_x : '0;
  assign origin_y      = gesture_valid ? down_y : '0;
  assign press_status  = status_next;

endmodule

### hdl/touch_gesture_classifier.sv
// Touch gesture classifier: one event word in, one result word out.
// An accepted event word passes through the input register and then the result register.
// Throughput: one event word per cycle; input stalls only while the input register
// and the result register are both full and the result word is held.
// Reset (synchronous, rst high): contact state cleared, thresholds to defaults,
// both pipeline registers empty.
module touch_gesture_classifier #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  gtc_event_if.sink                  evt,
  gtc_result_if.source               res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gtc_pkg::ADDR_W-1:0] paddr,
  input  logic [gtc_pkg::DATA_W-1:0] pwdata,
  output logic [gtc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import gtc_pkg::*;

  cfg_t cfg;

  // input register
  logic                  in_valid;
  op_t                   in_op;
  logic [COORD_BITS-1:0] in_x, in_y;

  // result register
  logic                  out_valid;
  logic                  out_gvalid;
  logic [GESTURE_W-1:0]  out_gesture;
  logic [COORD_BITS-1:0] out_ox, out_oy;
  logic [STATUS_W-1:0]   out_status;

  logic                  advance, step;
  logic                  c_gvalid;
  logic [GESTURE_W-1:0]  c_gesture;
  logic [COORD_BITS-1:0] c_ox, c_oy;
  logic [STATUS_W-1:0]   c_status;

  assign advance   = !out_valid || res.ready;
  assign step      = in_valid && advance;
  assign evt.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
    if (evt.valid && evt.ready) begin
      in_op <= op_t'(evt.operation);
      in_x  <= evt.x_coord;
      in_y  <= evt.y_coord;
    end
  end

  gtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtc_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (step),
    .op            (in_op),
    .x             (in_x),
    .y             (in_y),
    .gesture_valid (c_gvalid),
    .gesture       (c_gesture),
    .origin_x      (c_ox),
    .origin_y      (c_oy),
    .press_status  (c_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (step) begin
      out_gvalid  <= c_gvalid;
      out_gesture <= c_gesture;
      out_ox      <= c_ox;
      out_oy      <= c_oy;
      out_status  <= c_status;
    end
  end

  assign res.valid         = out_valid;
  assign res.gesture_valid = out_gvalid;
  assign res.gesture       = out_gesture;
  assign res.origin_x      = out_ox;
  assign res.origin_y      = out_oy;
  assign res.press_status  = out_status;

endmodule

### hdl/gtc_checker.sv
// Port-level checks on the result channel, bound to the top level.
module gtc_checker #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          gesture_valid,
  input logic [gtc_pkg::GESTURE_W-1:0] gesture,
  input logic [COORD_BITS-1:0]         origin_x,
  input logic [COORD_BITS-1:0]         origin_y,
  input logic [gtc_pkg::STATUS_W-1:0]  press_status
);
  import gtc_pkg::*;

  // nothing left in the pipeline after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_no_gesture_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !gesture_valid |-> gesture == G_TAP && origin_x == '0 && origin_y == '0)
    else $error("no-gesture word carries nonzero fields");

  // only evaluate yields a gesture, and it clears the press status
  a_gesture_eval: assert property (@(posedge clk) disable iff (rst)
    res_valid && gesture_valid |-> press_status == '0 && gesture <= G_LONG)
    else $error("gesture word with bad status or code");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> press_status <= STATUS_LIMIT)
    else $error("press status beyond saturation");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(gesture_valid) && $stable(gesture)
      && $stable(origin_x) && $stable(origin_y) && $stable(press_status))
    else $error("stalled result word changed");

endmodule

bind touch_gesture_classifier gtc_checker #(
  .COORD_BITS (COORD_BITS)
) u_gtc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .gesture_valid (res.gesture_valid),
  .gesture       (res.gesture),
  .origin_x      (res.origin_x),
  .origin_y      (res.origin_y),
  .press_status  (res.press_status)
);

### verif/testbench.sv
// Self-checking testbench for the touch gesture classifier: driver, monitor and gesture predictor.
module testbench;
  import gtc_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_ITEMS   = 72;

  // codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef logic [OP_W-1:0] op_code_t;
  typedef logic [CW-1:0]   coord_t;

  typedef struct packed {
    op_code_t op;
    coord_t   x;
    coord_t   y;
  } touch_word_t;

  typedef struct packed {
    logic                 found;
    logic [GESTURE_W-1:0] gesture;
    coord_t               origin_x;
    coord_t               origin_y;
    logic [STATUS_W-1:0]  status;
  } gesture_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  gtc_event_if  evt_if ();
  gtc_result_if res_if ();

  touch_gesture_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // thresholds and contact state as the block should hold them
  logic [SWIPE_W-1:0]  swipe_min = SWIPE_RST;
  logic [TICK_W-1:0]   tap_max   = TAP_RST;
  logic [TICK_W-1:0]   hold_min  = HOLD_RST;
  logic [STATUS_W-1:0] press_cnt = '0;
  logic [TICK_W-1:0]   tick_cnt  = '0;
  coord_t              down_x = '0;
  coord_t              down_y = '0;
  coord_t              lift_x = '0;
  coord_t              lift_y = '0;

  touch_word_t   touch_events[$];
  gesture_word_t predicted[$];
  touch_word_t   drv_word;
  gesture_word_t seen;
  gesture_word_t want;
  int            queued = 0;
  int            mismatches = 0;
  int            results_seen = 0;
  int            stall_cycles = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;

  function automatic gesture_word_t classify_event(input op_code_t op, input coord_t x,
                                                   input coord_t y);
    gesture_word_t r;
    coord_t        dx;
    coord_t        dy;
    logic          hit;
    gesture_t      g;
    r   = '0;
    hit = 1'b0;
    g   = G_TAP;
    case (op)
      OP_ARM: begin
        press_cnt = STATUS_ARM;
        tick_cnt  = '0;
        down_x    = '0;
        down_y    = '0;
        lift_x    = '0;
        lift_y    = '0;
      end
      OP_TICK: if (tick_cnt < TICK_LIMIT) tick_cnt = tick_cnt + 1'b1;
      OP_DOWN: begin
        if (press_cnt < STATUS_LIMIT) press_cnt = press_cnt + 1'b1;
        down_x = x;
        down_y = y;
      end
      OP_UP: begin
        lift_x = x;
        lift_y = y;
      end
      OP_EVAL: begin
        press_cnt = '0;
        dx = (down_x > lift_x) ? down_x - lift_x : lift_x - down_x;
        dy = (down_y > lift_y) ? down_y - lift_y : lift_y - down_y;
        if (lift_x == 0 && lift_y == 0 && down_x != 0 && down_y != 0) begin
          hit = 1'b1;
        end else if (dx > dy && dx > swipe_min) begin
          hit = 1'b1;
          g   = (down_x > lift_x) ? G_LEFT : G_RIGHT;
        end else if (dx <= dy && dy > swipe_min) begin
          hit = 1'b1;
          g   = (down_y > lift_y) ? G_UP : G_DOWN;
        end else if (tick_cnt < tap_max) begin
          // short contact, but an all-zero contact never happened
          hit = |{down_x, down_y, lift_x, lift_y};
        end else if (tick_cnt > hold_min) begin
          hit = !(down_x != 0 && down_y != 0 && lift_x != 0 && lift_y != 0);
          g   = G_LONG;
        end
      end
      default: ;
    endcase
    r.found  = hit;
    r.status = press_cnt;
    if (hit) begin
      r.gesture  = g;
      r.origin_x = down_x;
      r.origin_y = down_y;
    end
    return r;
  endfunction

  function automatic string show(input gesture_word_t w);
    return $sformatf("valid=%0b gesture=%0d origin=(%0d,%0d) status=%0d",
                     w.found, w.gesture, w.origin_x, w.origin_y, w.status);
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("ERROR: %s", msg);
  endfunction

  // driver: next word goes out once the current one has been taken
  always @(posedge clk) begin
    if (rst) begin
      evt_if.valid <= 1'b0;
    end else if (!evt_if.valid || evt_if.ready) begin
      if (touch_events.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        drv_word = touch_events.pop_front();
        evt_if.valid     <= 1'b1;
        evt_if.operation <= drv_word.op;
        evt_if.x_coord   <= drv_word.x;
        evt_if.y_coord   <= drv_word.y;
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // monitor: predict on each accepted event word, check each accepted result word
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_if.valid && evt_if.ready)
        predicted.push_back(classify_event(evt_if.operation, evt_if.x_coord, evt_if.y_coord));
      if (res_if.valid && res_if.ready) begin
        seen = {res_if.gesture_valid, res_if.gesture, res_if.origin_x, res_if.origin_y,
                res_if.press_status};
        results_seen++;
        if (predicted.size() == 0) begin
          log_mismatch($sformatf("result %0d with nothing pending: %s", results_seen,
                                 show(seen)));
        end else begin
          want = predicted.pop_front();
          if (seen !== want)
            log_mismatch($sformatf("result %0d: expected %s, got %s", results_seen,
                                   show(want), show(seen)));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("touch_gesture_classifier test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_event(input op_code_t op, input coord_t x, input coord_t y);
    touch_events.push_back('{op: op, x: x, y: y});
    queued++;
  endtask

  function automatic coord_t pick_coord();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return '0;
    if (roll < 5) return '1;
    return coord_t'($urandom);
  endfunction

  // every queued word has come back as a result
  task automatic wait_idle();
    @(posedge clk);
    while (results_seen < queued)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SWIPE: begin
        swipe_min = value[SWIPE_W-1:0];
        stored    = DATA_W'(swipe_min);
      end
      REG_TAP: begin
        tap_max = value[TICK_W-1:0];
        stored  = DATA_W'(tap_max);
      end
      default: begin
        hold_min = value[TICK_W-1:0];
        stored   = DATA_W'(hold_min);
      end
    endcase
    // read it straight back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored)
      log_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, prdata, stored));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits beyond each register are sometimes junk and must be dropped
  task automatic set_thresholds(input int swipe, input int tap, input int hold);
    logic [DATA_W-1:0] junk;
    junk = ($urandom_range(0, 2) == 0) ? $urandom : '0;
    write_reg(REG_SWIPE, {junk[DATA_W-1:SWIPE_W], SWIPE_W'(swipe)});
    write_reg(REG_TAP, {junk[DATA_W-1:TICK_W], TICK_W'(tap)});
    write_reg(REG_HOLD, {junk[DATA_W-1:TICK_W], TICK_W'(hold)});
  endtask

  // one contact: arm, presses, ticks, lift, evaluate, with the odd step missing or evaluate repeated
  task automatic add_contact();
    int     n_down;
    int     n_tick;
    int     roll;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t travel;
    coord_t wobble;
    if ($urandom_range(0, 9) != 0) push_event(OP_ARM, coord_t'($urandom), coord_t'($urandom));
    n_down = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 2);
    sx = '0;
    sy = '0;
    repeat (n_down) begin
      sx = pick_coord();
      sy = pick_coord();
      push_event(OP_DOWN, sx, sy);
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) n_tick = $urandom_range(0, 6);
    else if (roll < 8) n_tick = int'(tap_max) + int'($urandom_range(0, 4)) - 2;
    else n_tick = int'(hold_min) + int'($urandom_range(0, 4)) - 2;
    if (n_tick < 0 || n_tick > 70) n_tick = $urandom_range(0, 6);
    repeat (n_tick) push_event(OP_TICK, coord_t'($urandom), coord_t'($urandom));
    // travel straddles the swipe threshold
    travel = coord_t'(swipe_min) + coord_t'($urandom_range(0, 2)) - 1'b1;
    wobble = coord_t'($urandom_range(0, 3));
    roll   = $urandom_range(0, 9);
    case (roll)
      0, 1: begin
        ex = '0;
        ey = '0;
      end
      2, 3: begin
        ex = roll[0] ? sx + travel : sx - travel;
        ey = sy + wobble;
      end
      4, 5: begin
        ex = sx + wobble;
        ey = roll[0] ? sy + travel : sy - travel;
      end
      6, 7: begin
        ex = sx;
        ey = sy;
      end
      default: begin
        ex = pick_coord();
        ey = pick_coord();
      end
    endcase
    if ($urandom_range(0, 9) != 0) push_event(OP_UP, ex, ey);
    push_event(OP_EVAL, coord_t'($urandom), coord_t'($urandom));
    if ($urandom_range(0, 9) == 0) push_event(OP_EVAL, coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct);
    int first;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    first = queued;
    while (queued - first < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 2)
        push_event(op_code_t'($urandom_range(OP_ARM, OP_SPARE_LAST)), coord_t'($urandom),
                   coord_t'($urandom));
      else
        add_contact();
    end
    wait_idle();
  endtask

  initial begin
    evt_if.valid     = 1'b0;
    evt_if.operation = '0;
    evt_if.x_coord   = '0;
    evt_if.y_coord   = '0;
    res_if.ready     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset thresholds
    push_event(OP_EVAL, '1, '1);
    push_event(OP_SPARE_FIRST, '1, '1);
    push_event(OP_SPARE_LAST, '0, '0);
    push_event(OP_ARM, '1, '1);
    push_event(OP_DOWN, '1, '1);
    push_event(OP_UP, '0, '0);
    push_event(OP_EVAL, '0, '0);
    push_event(OP_ARM, '0, '0);
    push_event(OP_DOWN, '0, '0);
    push_event(OP_UP, '1, '0);
    push_event(OP_EVAL, '1, '1);
    push_event(OP_DOWN, '1, '0);
    push_event(OP_UP, '0, '1);
    push_event(OP_EVAL, '0, '0);
    push_event(OP_DOWN, 12'd100, 12'd100);
    push_event(OP_TICK, '1, '1);
    push_event(OP_UP, 12'd105, 12'd103);
    push_event(OP_EVAL, '0, '0);
    push_event(OP_ARM, '0, '0);
    push_event(OP_DOWN, 12'd800, 12'd800);
    push_event(OP_UP, 12'd800, 12'd811);
    push_event(OP_EVAL, '0, '0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_thresholds(0, 0, 0);
        1: set_thresholds(4095, 10000, 10000);
        3: set_thresholds(10, 30, 150);
        4: set_thresholds($urandom_range(0, 4095), 16383, $urandom_range(0, 60));
        6: set_thresholds(4095, 0, 0);
        default: set_thresholds($urandom_range(0, 300), $urandom_range(0, 40),
                                $urandom_range(0, 50));
      endcase
      case (phase % 4)
        0: run_phase(0, 0);
        1: run_phase(78, 0);
        2: run_phase(0, 78);
        default: run_phase(26, 26);
      endcase
    end

    if (mismatches == 0 && predicted.size() == 0) begin
      $display("touch_gesture_classifier test passed");
    end else begin
      $display("touch_gesture_classifier test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gtc_pkg.sv
hdl/gtc_event_if.sv
hdl/gtc_result_if.sv
hdl/gtc_regs.sv
hdl/gtc_engine.sv
hdl/touch_gesture_classifier.sv
hdl/gtc_checker.sv
verif/testbench.sv
